[hw/rtl/aras_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aras_pkg
// shared constants, codes and controller/datapath interface types for the
// accelerometer range autoscaler
// ----------------------------------------------------------------------------
package aras_pkg;

    localparam int POINTS   = 16;
    localparam int PT_W     = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CNT_W    = $clog2(6 * POINTS + 1);
    localparam int AXIS_W   = 8;
    localparam int ENTRY_W  = 3 * AXIS_W;
    localparam int INDEX_W  = 8;
    localparam int LIMIT_W  = 8;
    localparam int COUNT_W  = 11;
    localparam int RANGE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [LIMIT_W-1:0] UPPER_RST     = 8'h70;
    localparam logic [LIMIT_W-1:0] LOWER_RST     = 8'h30;
    localparam logic [COUNT_W-1:0] THRESHOLD_RST = 11'd10;
    localparam logic [RANGE_W-1:0] TOP_RST       = 2'd3;
    localparam logic [AXIS_W-1:0]  MAX_RST       = 8'h80;
    localparam logic [AXIS_W-1:0]  MIN_RST       = 8'h7F;

    typedef enum logic [1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_SCALE_UP   = 2'd1,
        CMD_SCALE_DOWN = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER     = 2'd0,
        REG_LOWER     = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_TOP       = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] upper_limit;
        logic [LIMIT_W-1:0] lower_limit;
        logic [COUNT_W-1:0] count_threshold;
        logic [RANGE_W-1:0] top_range;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic rd_walk;
        logic wr_en;
        logic walk_clr;
        logic walk_step;
        logic clear_all;
        logic decide;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd item_cmd;
        logic cycle_done;
        logic pt_in_range;
        logic walk_last;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/aras_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aras_ctrl
// sequencer: accepts one beat, dispatches on its command, walks the point
// store for checks and hands the result to the output register
// ----------------------------------------------------------------------------
module aras_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  aras_pkg::t_dp_sts  i_sts,
    output aras_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_WRITE    = 7'b0000100,
        S_WALK     = 7'b0001000,
        S_DRAIN    = 7'b0010000,
        S_DECIDE   = 7'b0100000,
        S_OUT      = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_OUT;
                unique case (i_sts.item_cmd) inside
                    aras_pkg::CMD_SAMPLE: begin
                        if (i_sts.pt_in_range) begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_WRITE;
                        end
                    end
                    aras_pkg::CMD_SCALE_UP, aras_pkg::CMD_SCALE_DOWN: begin
                        if (i_sts.cycle_done) begin
                            o_cmd.walk_clr = 1'b1;
                            n_state        = S_WALK;
                        end
                    end
                    aras_pkg::CMD_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                    end
                endcase
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_OUT;
            end
            S_WALK: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_walk   = 1'b1;
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

endmodule

[hw/rtl/aras_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aras_dp
// datapath: item register, extreme stores with per-point valid bits, walk
// accumulator, range register and output register
// ----------------------------------------------------------------------------
module aras_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  aras_pkg::t_cfg                  i_cfg,
    input  aras_pkg::t_dp_cmd               i_cmd,
    output aras_pkg::t_dp_sts               o_sts,
    input  aras_pkg::t_cmd                  i_item_cmd,
    input  logic [aras_pkg::INDEX_W-1:0]    i_point_index,
    input  logic [aras_pkg::ENTRY_W-1:0]    i_samples,
    input  logic                            i_cycle_done,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [aras_pkg::RANGE_W-1:0]    o_range_index,
    output logic                            o_range_changed,
    output logic [aras_pkg::COUNT_W-1:0]    o_over_count
);

    localparam int PT_W   = aras_pkg::PT_W;
    localparam int CNT_W  = aras_pkg::CNT_W;
    localparam int AW     = aras_pkg::AXIS_W;
    localparam int EW     = aras_pkg::ENTRY_W;

    // item register
    aras_pkg::t_cmd                r_cmd;
    logic [aras_pkg::INDEX_W-1:0]  r_pt;
    logic [EW-1:0]                 r_samp;
    logic                          r_done;

    // extreme stores
    logic [EW-1:0]      r_max_mem [aras_pkg::POINTS];
    logic [EW-1:0]      r_min_mem [aras_pkg::POINTS];
    logic [aras_pkg::POINTS-1:0] r_valid;
    logic [EW-1:0]      r_rd_max;
    logic [EW-1:0]      r_rd_min;
    logic               r_rd_vbit;
    logic               r_acc_pend;
    logic [PT_W-1:0]    rd_addr;
    logic [PT_W-1:0]    pt_addr;
    logic [EW-1:0]      max_eff;
    logic [EW-1:0]      min_eff;
    logic [EW-1:0]      new_max;
    logic [EW-1:0]      new_min;

    // walk and decision state
    logic [PT_W-1:0]    r_walk_cnt;
    logic [CNT_W-1:0]   r_over;
    logic               r_within;
    logic [2:0]         hits;
    logic               any_above_lower;
    logic [aras_pkg::RANGE_W-1:0] r_range;
    logic [aras_pkg::RANGE_W-1:0] n_range;
    logic               r_changed;
    logic               n_changed;

    // output register
    logic                          r_out_valid;
    logic [aras_pkg::RANGE_W-1:0]  r_out_range;
    logic                          r_out_changed;
    logic [aras_pkg::COUNT_W-1:0]  r_out_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_item_cmd;
            r_pt   <= i_point_index;
            r_samp <= i_samples;
            r_done <= i_cycle_done;
        end
    end

    assign pt_addr = r_pt[PT_W-1:0];
    assign rd_addr = i_cmd.rd_walk ? r_walk_cnt : pt_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_max  <= r_max_mem[rd_addr];
            r_rd_min  <= r_min_mem[rd_addr];
            r_rd_vbit <= r_valid[rd_addr];
        end
        if (i_cmd.wr_en) begin
            r_max_mem[pt_addr] <= new_max;
            r_min_mem[pt_addr] <= new_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[pt_addr] <= 1'b1;
        end
    end

    // a never-written or cleared point reads as its reset extremes
    assign max_eff = r_rd_vbit ? r_rd_max : {3{aras_pkg::MAX_RST}};
    assign min_eff = r_rd_vbit ? r_rd_min : {3{aras_pkg::MIN_RST}};

    always_comb begin
        logic signed [AW-1:0] s;
        logic signed [AW-1:0] mx;
        logic signed [AW-1:0] mn;
        new_max = '0;
        new_min = '0;
        for (int a = 0; a < 3; a++) begin
            s  = signed'(r_samp[a*AW +: AW]);
            mx = signed'(max_eff[a*AW +: AW]);
            mn = signed'(min_eff[a*AW +: AW]);
            new_max[a*AW +: AW] = (s > mx) ? s : mx;
            new_min[a*AW +: AW] = (s < mn) ? s : mn;
        end
    end

    function automatic logic [AW-1:0] mag(input logic [AW-1:0] v);
        // magnitude of -128 comes out as 128 in unsigned form
        return v[AW-1] ? (~v + AW'(1)) : v;
    endfunction

    always_comb begin
        logic [AW-1:0] m;
        hits            = '0;
        any_above_lower = 1'b0;
        for (int a = 0; a < 3; a++) begin
            m = mag(max_eff[a*AW +: AW]);
            hits = hits + 3'(m > i_cfg.upper_limit);
            any_above_lower = any_above_lower | (m > i_cfg.lower_limit);
            m = mag(min_eff[a*AW +: AW]);
            hits = hits + 3'(m > i_cfg.upper_limit);
            any_above_lower = any_above_lower | (m > i_cfg.lower_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_pend <= 1'b0;
        end else begin
            r_acc_pend <= i_cmd.rd_en & i_cmd.rd_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_cnt <= '0;
            r_over     <= '0;
            r_within   <= 1'b1;
        end else if (i_cmd.walk_clr) begin
            r_walk_cnt <= '0;
            r_over     <= '0;
            r_within   <= 1'b1;
        end else begin
            if (i_cmd.walk_step) begin
                r_walk_cnt <= r_walk_cnt + PT_W'(1);
            end
            if (r_acc_pend) begin
                r_over   <= r_over + CNT_W'(hits);
                r_within <= r_within & ~any_above_lower;
            end
        end
    end

    always_comb begin
        n_range   = r_range;
        n_changed = 1'b0;
        if (r_cmd == aras_pkg::CMD_SCALE_UP) begin
            if ((aras_pkg::COUNT_W'(r_over) > i_cfg.count_threshold) &&
                (r_range < i_cfg.top_range)) begin
                n_range   = r_range + aras_pkg::RANGE_W'(1);
                n_changed = 1'b1;
            end
        end else if (r_cmd == aras_pkg::CMD_SCALE_DOWN) begin
            if (r_within && (r_range != '0)) begin
                n_range   = r_range - aras_pkg::RANGE_W'(1);
                n_changed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range   <= '0;
            r_changed <= 1'b0;
        end else if (i_cmd.capture) begin
            r_changed <= 1'b0;
        end else if (i_cmd.decide) begin
            r_range   <= n_range;
            r_changed <= n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_range   <= r_range;
            r_out_changed <= r_changed;
            r_out_count   <= ((r_cmd == aras_pkg::CMD_SCALE_UP) && r_done) ?
                             aras_pkg::COUNT_W'(r_over) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_range_index   = r_out_range;
    assign o_range_changed = r_out_changed;
    assign o_over_count    = r_out_count;

    assign o_sts.item_cmd    = r_cmd;
    assign o_sts.cycle_done  = r_done;
    assign o_sts.pt_in_range = ({1'b0, r_pt} < (aras_pkg::INDEX_W + 1)'(aras_pkg::POINTS));
    assign o_sts.walk_last   = (r_walk_cnt == PT_W'(aras_pkg::POINTS - 1));
    assign o_sts.out_free    = ~r_out_valid | i_out_ready;

    a_no_wr_with_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> !i_cmd.clear_all)
        else $error("store write and clear in the same cycle");

    a_load_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while a result waits");

    a_change_moves_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && n_changed) |=> (r_range != $past(r_range)))
        else $error("range change flagged without a new range");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over <= CNT_W'(6 * aras_pkg::POINTS))
        else $error("over-limit count exceeds six per point");

endmodule

[hw/rtl/accel_range_autoscaler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_range_autoscaler_unit
// per-point max/min tracking of a three-axis accelerometer with range
// index scale-up and scale-down checks
// ----------------------------------------------------------------------------
// a sample to a stored point is read in dispatch, written back, then loaded
//   to the output; a clear, an ignored sample or a check with cycle_done low
//   goes from dispatch to the output load; the next beat waits for that load
// a check with cycle_done high walks the store one point a cycle through its
//   single read port, then drains and decides before the output load
// reset: config to defaults, range index 0, point valid bits cleared at once
// ----------------------------------------------------------------------------
module accel_range_autoscaler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] point_index, [15:8] sample_x, [23:16] sample_y, [31:24] sample_z,
    // [32] cycle_done, [39:33] zero
    input  logic [39:0]                       s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                        s_axis_tuser,
    // result beats
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] range_index, [2] range_changed, [13:3] over_count, [15:14] zero
    output logic [15:0]                       m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aras_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aras_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    aras_pkg::t_cfg     r_cfg;
    aras_pkg::t_dp_cmd  dp_cmd;
    aras_pkg::t_dp_sts  dp_sts;

    logic [aras_pkg::RANGE_W-1:0] out_range;
    logic                         out_changed;
    logic [aras_pkg::COUNT_W-1:0] out_count;

    // config writes are always taken; register index decodes to a field
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_limit     <= aras_pkg::UPPER_RST;
            r_cfg.lower_limit     <= aras_pkg::LOWER_RST;
            r_cfg.count_threshold <= aras_pkg::THRESHOLD_RST;
            r_cfg.top_range       <= aras_pkg::TOP_RST;
        end else if (i_cfg_valid) begin
            unique case (aras_pkg::t_reg_idx'(i_cfg_index))
                aras_pkg::REG_UPPER:
                    r_cfg.upper_limit <= i_cfg_data[aras_pkg::LIMIT_W-1:0];
                aras_pkg::REG_LOWER:
                    r_cfg.lower_limit <= i_cfg_data[aras_pkg::LIMIT_W-1:0];
                aras_pkg::REG_THRESHOLD:
                    r_cfg.count_threshold <= i_cfg_data[aras_pkg::COUNT_W-1:0];
                aras_pkg::REG_TOP:
                    r_cfg.top_range <= i_cfg_data[aras_pkg::RANGE_W-1:0];
            endcase
        end
    end

    // sequencer
    aras_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // stores, accumulator, range and output register
    aras_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_item_cmd      (aras_pkg::t_cmd'(s_axis_tuser)),
        .i_point_index   (s_axis_tdata[7:0]),
        .i_samples       (s_axis_tdata[31:8]),
        .i_cycle_done    (s_axis_tdata[32]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_range_index   (out_range),
        .o_range_changed (out_changed),
        .o_over_count    (out_count)
    );

    assign m_axis_tdata = {2'b00, out_count, out_changed, out_range};

endmodule
